// File: src/tcw_pkg.sv
// Shared widths, codes and the command type of the text console writer.
package tcw_pkg;

   localparam int KIND_W = 2;
   localparam int CHAR_W = 8;
   localparam int RCOL_W = 7;
   localparam int RROW_W = 5;
   localparam int OCOL_W = 7;
   localparam int OROW_W = 5;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_NULL    = 8'h00;

   typedef logic [2:0] op_type;

   localparam op_type OP_NONE    = 3'd0;
   localparam op_type OP_CHAR    = 3'd1;
   localparam op_type OP_NEWLINE = 3'd2;
   localparam op_type OP_CLEAR   = 3'd3;
   localparam op_type OP_READ    = 3'd4;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   char_code;
      logic [RCOL_W-1:0]   read_column;
      logic [RROW_W-1:0]   read_row;
   } cmd_type;

endpackage

// File: src/tcw_req_if.sv
// Request channel: valid/ready handshake with the console command payload.
interface tcw_req_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [CHAR_W-1:0] char_code;
   logic [RCOL_W-1:0] read_column;
   logic [RROW_W-1:0] read_row;

   modport source (output valid, output kind, output char_code, output read_column,
                   output read_row, input ready);
   modport sink (input valid, input kind, input char_code, input read_column,
                 input read_row, output ready);
endinterface

// File: src/tcw_rsp_if.sv
// Response channel: valid/ready handshake with the cursor and cell payload.
interface tcw_rsp_if import tcw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OCOL_W-1:0] cursor_column;
   logic [OROW_W-1:0] cursor_row;
   logic [CHAR_W-1:0] cell_char;

   modport source (output valid, output cursor_column, output cursor_row,
                   output cell_char, input ready);
   modport sink (input valid, input cursor_column, input cursor_row,
                 input cell_char, output ready);
endinterface

// File: src/tcw_front.sv
// Front end: takes request beats and classifies them into console commands.
module tcw_front import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   tcw_req_if.sink  req_ch,
   output logic     push_valid,
   input  logic     push_ready,
   output cmd_type  push_cmd
);

   logic in_range;

   assign in_range = (int'(req_ch.read_column) < COLUMNS) && (int'(req_ch.read_row) < ROWS);

   always_comb begin
      push_cmd.char_code   = req_ch.char_code;
      push_cmd.read_column = req_ch.read_column;
      push_cmd.read_row    = req_ch.read_row;
      case (req_ch.kind)
         KIND_WRITE: begin
            if (req_ch.char_code == CHAR_NULL) begin
               push_cmd.op = OP_NONE;
            end else if (req_ch.char_code == CHAR_NEWLINE) begin
               push_cmd.op = OP_NEWLINE;
            end else begin
               push_cmd.op = OP_CHAR;
            end
         end
         KIND_CLEAR: begin
            push_cmd.op = OP_CLEAR;
         end
         KIND_READ: begin
            // A read outside the grid reports a zero cell like an unused kind.
            push_cmd.op = in_range ? OP_READ : OP_NONE;
         end
         default: begin
            push_cmd.op = OP_NONE;
         end
      endcase
   end

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

endmodule

// File: src/tcw_queue.sv
// Two-entry command queue between the front end and the execution engine.
module tcw_queue import tcw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: src/tcw_back.sv
// Execution engine: cursor, screen memory with a rotating top row, row and
// screen blanking sweeps, and the response register.
module tcw_back import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  cmd_type   pop_cmd,
   tcw_rsp_if.source rsp_ch
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS + 1);
   localparam int PW    = $clog2(ROWS);

   localparam logic [1:0] ST_SWEEP = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [1:0]        ret_ff, ret_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [PW-1:0]     top_ff, top_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic [AW-1:0]     end_ff, end_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OCOL_W-1:0] rsp_col_ff;
   logic [OROW_W-1:0] rsp_row_ff;
   logic [CHAR_W-1:0] rsp_cell_ff;
   logic [CHAR_W-1:0] rdata_ff;

   logic [CHAR_W-1:0] mem [CELLS];

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CHAR_W-1:0] mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic              load_rsp;
   logic              finish;
   logic              slot_free;
   logic              pending;
   logic [PW-1:0]     top_next;
   logic [PW-1:0]     cur_phys;
   logic [PW-1:0]     rd_phys;
   logic [CW+RCOL_W-1:0] rc_wide;
   logic [PW+RROW_W-1:0] rr_wide;
   logic [CW+OCOL_W-1:0] oc_wide;
   logic [RW+OROW_W-1:0] or_wide;

   // Logical row r lives in physical row (r + top) mod ROWS.
   function automatic logic [PW-1:0] phys_row(input logic [PW-1:0] r,
                                              input logic [PW-1:0] top);
      logic [PW:0] s;
      s = {1'b0, r} + {1'b0, top};
      if (s >= (PW + 1)'(ROWS)) begin
         s = s - (PW + 1)'(ROWS);
      end
      return s[PW-1:0];
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [PW-1:0] pr,
                                               input logic [CW-1:0] c);
      return AW'(pr) * AW'(COLUMNS) + AW'(c);
   endfunction

   assign pending   = (row_ff == RW'(ROWS));
   assign top_next  = (top_ff == PW'(ROWS - 1)) ? '0 : top_ff + PW'(1);
   assign cur_phys  = phys_row(row_ff[PW-1:0], top_ff);
   assign rc_wide   = {{CW{1'b0}}, cmd_ff.read_column};
   assign rr_wide   = {{PW{1'b0}}, cmd_ff.read_row};
   assign rd_phys   = phys_row(rr_wide[PW-1:0], top_ff);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign oc_wide   = {{OCOL_W{1'b0}}, col_in};
   assign or_wide   = {{OROW_W{1'b0}}, row_in};

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cmd_in    = cmd_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      top_in    = top_ff;
      sweep_in  = sweep_ff;
      end_in    = end_ff;
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = CHAR_BLANK;
      mem_re    = 1'b0;
      mem_raddr = '0;
      pop_ready = 1'b0;
      load_rsp  = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         ST_SWEEP: begin
            mem_we = 1'b1;
            if (sweep_ff == end_ff) begin
               state_in = ret_ff;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cmd_in   = pop_cmd;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff.op)
               OP_CLEAR: begin
                  col_in   = '0;
                  row_in   = '0;
                  top_in   = '0;
                  sweep_in = '0;
                  end_in   = AW'(CELLS - 1);
                  ret_in   = ST_DONE;
                  state_in = ST_SWEEP;
               end
               OP_READ: begin
                  mem_re    = 1'b1;
                  mem_raddr = cell_addr(rd_phys, rc_wide[CW-1:0]);
                  state_in  = ST_DONE;
               end
               OP_CHAR, OP_NEWLINE: begin
                  if (pending) begin
                     // Take the pending scroll first, then run this command again.
                     row_in   = RW'(ROWS - 1);
                     col_in   = '0;
                     sweep_in = cell_addr(top_ff, '0);
                     end_in   = cell_addr(top_ff, CW'(COLUMNS - 1));
                     top_in   = top_next;
                     ret_in   = ST_EXEC;
                     state_in = ST_SWEEP;
                  end else if (cmd_ff.op == OP_CHAR) begin
                     mem_we    = 1'b1;
                     mem_waddr = cell_addr(cur_phys, col_ff);
                     mem_wdata = cmd_ff.char_code;
                     if (col_ff == CW'(COLUMNS - 1)) begin
                        col_in = '0;
                        row_in = row_ff + RW'(1);
                     end else begin
                        col_in = col_ff + CW'(1);
                     end
                     finish = 1'b1;
                  end else begin
                     col_in = '0;
                     if (row_ff == RW'(ROWS - 1)) begin
                        // Newline on the bottom row scrolls and stays there.
                        sweep_in = cell_addr(top_ff, '0);
                        end_in   = cell_addr(top_ff, CW'(COLUMNS - 1));
                        top_in   = top_next;
                        ret_in   = ST_DONE;
                        state_in = ST_SWEEP;
                     end else begin
                        row_in = row_ff + RW'(1);
                        finish = 1'b1;
                     end
                  end
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
            if (finish) begin
               if (slot_free) begin
                  load_rsp = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         ret_ff       <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         top_ff       <= '0;
         sweep_ff     <= '0;
         end_ff       <= AW'(CELLS - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         top_ff       <= top_in;
         sweep_ff     <= sweep_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (load_rsp) begin
         rsp_col_ff  <= oc_wide[OCOL_W-1:0];
         rsp_row_ff  <= or_wide[OROW_W-1:0];
         rsp_cell_ff <= (cmd_ff.op == OP_READ) ? rdata_ff : CHAR_NULL;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.cursor_column = rsp_col_ff;
   assign rsp_ch.cursor_row    = rsp_row_ff;
   assign rsp_ch.cell_char     = rsp_cell_ff;

endmodule

// File: src/text_console_writer_top.sv
// Top level of the text console writer: front end, command queue, engine.
//
//   channel   dir   handshake       payload
//   req_ch    in    valid / ready   kind, char_code, read_column, read_row
//   rsp_ch    out   valid / ready   cursor_column, cursor_row, cell_char
//
// A printable byte, newline or ignored item passes through the engine's pop and execute states;
// a read adds a done state, since the screen memory read port is registered.
// A scroll adds the blanking sweep that clears one row; clear adds the full-screen
// sweep.
// After reset the engine sweeps all ROWS * COLUMNS cells to blanks before its first item;
// the queue still takes up to two beats meanwhile.
// A stalled response holds in its register and the queue absorbs two more requests.
module text_console_writer_top import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_ch,
   tcw_rsp_if.source rsp_ch
);

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_ch    (rsp_ch)
   );

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid after reset");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (ROWS > 31) || (int'(rsp_ch.cursor_row) <= ROWS))
      else $error("cursor row beyond pending row");

   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (COLUMNS > 127) || (int'(rsp_ch.cursor_column) < COLUMNS))
      else $error("cursor column beyond last column");

   a_pending_home: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (ROWS < 32) && (int'(rsp_ch.cursor_row) == ROWS)
      |-> (rsp_ch.cursor_column == '0))
      else $error("pending scroll with nonzero column");

endmodule

// File: test/testbench.sv
// Testbench for text_console_writer_top: directed table and random text against a screen model.
`timescale 1ns / 100ps

module testbench;
   import tcw_pkg::*;

   localparam int CON_COLUMNS  = 80;
   localparam int CON_ROWS     = 25;
   localparam int CON_CELLS    = CON_COLUMNS * CON_ROWS;
   localparam int RANDOM_ITEMS = 1950;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 20_000_000;
   localparam int MAX_PRINTED  = 100;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [OCOL_W-1:0] column;
      logic [OROW_W-1:0] row;
      logic [CHAR_W-1:0] glyph;
   } console_view_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] char_code;
      logic [RCOL_W-1:0] read_column;
      logic [RROW_W-1:0] read_row;
      logic              typed;
      console_view_type  want;
   } console_cmd_type;

   localparam console_view_type NO_VIEW = '0;

   logic clock = 1'b0;
   logic reset;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();

   text_console_writer_top #(
      .COLUMNS(CON_COLUMNS),
      .ROWS   (CON_ROWS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the screen and cursor, updated once per accepted command.
   logic [CHAR_W-1:0] shadow_screen [CON_CELLS];
   int unsigned       shadow_cursor;
   console_view_type  awaited_views [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   bit                send_eager = 1'b0;
   bit                take_eager = 1'b0;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("MISMATCH cycle %0d: %s", cycle_count, what);
      end
   endtask

   function automatic void blank_shadow();
      for (int i = 0; i < CON_CELLS; i++) shadow_screen[i] = CHAR_BLANK;
      shadow_cursor = 0;
   endfunction

   function automatic void scroll_shadow();
      for (int i = 0; i < CON_CELLS - CON_COLUMNS; i++) begin
         shadow_screen[i] = shadow_screen[i + CON_COLUMNS];
      end
      for (int i = CON_CELLS - CON_COLUMNS; i < CON_CELLS; i++) shadow_screen[i] = CHAR_BLANK;
      if (shadow_cursor >= CON_COLUMNS) begin
         shadow_cursor -= CON_COLUMNS;
      end else begin
         shadow_cursor = 0;
      end
   endfunction

   function automatic console_view_type apply_console_cmd(input console_cmd_type cmd);
      console_view_type view;
      view = NO_VIEW;
      case (cmd.kind)
         KIND_WRITE: begin
            if (cmd.char_code != CHAR_NULL) begin
               // A cursor parked past the last cell scrolls before anything else.
               if (shadow_cursor >= CON_CELLS) scroll_shadow();
               if (cmd.char_code == CHAR_NEWLINE) begin
                  shadow_cursor = (shadow_cursor / CON_COLUMNS + 1) * CON_COLUMNS;
                  if (shadow_cursor >= CON_CELLS) scroll_shadow();
               end else begin
                  shadow_screen[shadow_cursor] = cmd.char_code;
                  shadow_cursor++;
               end
            end
         end
         KIND_CLEAR: begin
            blank_shadow();
         end
         KIND_READ: begin
            if (cmd.read_column < CON_COLUMNS && cmd.read_row < CON_ROWS) begin
               view.glyph = shadow_screen[int'(cmd.read_row) * CON_COLUMNS
                                          + int'(cmd.read_column)];
            end
         end
         default: ;
      endcase
      view.column = OCOL_W'(shadow_cursor % CON_COLUMNS);
      view.row    = OROW_W'(shadow_cursor / CON_COLUMNS);
      return view;
   endfunction

   function automatic console_cmd_type cmd_row(input logic [KIND_W-1:0] kind,
                                               input logic [CHAR_W-1:0] char_code,
                                               input logic [RCOL_W-1:0] read_column,
                                               input logic [RROW_W-1:0] read_row,
                                               input logic              typed,
                                               input console_view_type  want);
      console_cmd_type cmd;
      cmd.kind        = kind;
      cmd.char_code   = char_code;
      cmd.read_column = read_column;
      cmd.read_row    = read_row;
      cmd.typed       = typed;
      cmd.want        = want;
      return cmd;
   endfunction

   // Mode 0 is chatty text with newlines, mode 1 long lines that wrap and
   // park the cursor at the bottom, mode 2 mostly reads of the screen.
   function automatic console_cmd_type random_console_cmd(input int mode);
      console_cmd_type cmd;
      int              pick;
      pick = $urandom_range(0, 99);
      cmd = cmd_row(KIND_WRITE, CHAR_W'($urandom_range(0, 255)),
                    RCOL_W'($urandom_range(0, 127)), RROW_W'($urandom_range(0, 31)),
                    1'b0, NO_VIEW);
      case (mode)
         0: begin
            if (pick >= 70 && pick < 80) cmd.char_code = CHAR_NEWLINE;
            else if (pick >= 80 && pick < 82) cmd.char_code = CHAR_NULL;
            else if (pick >= 82 && pick < 97) cmd.kind = KIND_READ;
            else if (pick >= 97) cmd.kind = KIND_UNUSED;
         end
         1: begin
            if (pick >= 85 && pick < 87) cmd.char_code = CHAR_NEWLINE;
            else if (pick >= 87 && pick < 89) cmd.char_code = CHAR_NULL;
            else if (pick >= 89 && pick < 99) cmd.kind = KIND_READ;
            else if (pick >= 99) cmd.kind = KIND_UNUSED;
         end
         default: begin
            if (pick < 60) cmd.kind = KIND_READ;
         end
      endcase
      // Most reads land on the screen; the rest cover every address bit.
      if (cmd.kind == KIND_READ && $urandom_range(0, 4) != 0) begin
         cmd.read_column = RCOL_W'($urandom_range(0, CON_COLUMNS - 1));
         cmd.read_row    = RROW_W'($urandom_range(0, CON_ROWS - 1));
      end
      return cmd;
   endfunction

   task automatic send_cmd(input console_cmd_type cmd);
      int               gap;
      console_view_type predicted;
      gap = send_eager ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= cmd.kind;
      req_ch.char_code   <= cmd.char_code;
      req_ch.read_column <= cmd.read_column;
      req_ch.read_row    <= cmd.read_row;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_console_cmd(cmd);
      awaited_views.push_back(cmd.typed ? cmd.want : predicted);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", awaited_views.size());
         $display("text_console_writer_top test failed");
         $finish;
      end
   end

   // Result side: random stall before each beat, then compare with the oldest prediction.
   initial begin
      int               stall;
      console_view_type want;
      console_view_type seen;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 99) == 0) take_eager = !take_eager;
         stall = take_eager ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         seen = {rsp_ch.cursor_column, rsp_ch.cursor_row, rsp_ch.cell_char};
         if (awaited_views.size() == 0) begin
            report_mismatch($sformatf("result beat col %0d row %0d char %02h with none pending",
                                      seen.column, seen.row, seen.glyph));
         end else begin
            want = awaited_views.pop_front();
            if (seen.column != want.column)
               report_mismatch($sformatf("cursor_column %0d, expected %0d",
                                         seen.column, want.column));
            if (seen.row != want.row)
               report_mismatch($sformatf("cursor_row %0d, expected %0d",
                                         seen.row, want.row));
            if (seen.glyph != want.glyph)
               report_mismatch($sformatf("cell_char %02h, expected %02h",
                                         seen.glyph, want.glyph));
         end
      end
   end

   initial begin
      console_cmd_type directed_rows [$];
      console_cmd_type cmd;
      int              random_count;
      int              seg_mode;
      int              seg_len;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= KIND_WRITE;
      req_ch.char_code   <= CHAR_NULL;
      req_ch.read_column <= '0;
      req_ch.read_row    <= '0;
      blank_shadow();

      directed_rows = '{
         cmd_row(KIND_READ,   8'h00,        7'd0,   5'd0,  1'b1, {7'd0, 5'd0, CHAR_BLANK}),
         cmd_row(KIND_READ,   8'hff,        7'd79,  5'd24, 1'b1, {7'd0, 5'd0, CHAR_BLANK}),
         cmd_row(KIND_READ,   8'h00,        7'd127, 5'd31, 1'b1, {7'd0, 5'd0, 8'h00}),
         cmd_row(KIND_READ,   8'h00,        7'd80,  5'd0,  1'b1, {7'd0, 5'd0, 8'h00}),
         cmd_row(KIND_READ,   8'h00,        7'd0,   5'd25, 1'b1, {7'd0, 5'd0, 8'h00}),
         cmd_row(KIND_UNUSED, 8'hff,        7'd127, 5'd31, 1'b1, {7'd0, 5'd0, 8'h00}),
         cmd_row(KIND_WRITE,  CHAR_NULL,    7'd127, 5'd31, 1'b1, {7'd0, 5'd0, 8'h00}),
         cmd_row(KIND_WRITE,  8'h41,        7'd0,   5'd0,  1'b1, {7'd1, 5'd0, 8'h00}),
         cmd_row(KIND_WRITE,  8'hff,        7'd0,   5'd0,  1'b1, {7'd2, 5'd0, 8'h00}),
         cmd_row(KIND_WRITE,  8'h01,        7'd0,   5'd0,  1'b1, {7'd3, 5'd0, 8'h00}),
         cmd_row(KIND_READ,   8'h00,        7'd0,   5'd0,  1'b1, {7'd3, 5'd0, 8'h41}),
         cmd_row(KIND_READ,   8'h00,        7'd1,   5'd0,  1'b1, {7'd3, 5'd0, 8'hff}),
         cmd_row(KIND_WRITE,  CHAR_NEWLINE, 7'd0,   5'd0,  1'b1, {7'd0, 5'd1, 8'h00}),
         cmd_row(KIND_WRITE,  CHAR_BLANK,   7'd0,   5'd0,  1'b0, NO_VIEW),
         cmd_row(KIND_WRITE,  8'h80,        7'd0,   5'd0,  1'b0, NO_VIEW),
         cmd_row(KIND_READ,   8'hff,        7'd1,   5'd1,  1'b0, NO_VIEW),
         cmd_row(KIND_CLEAR,  8'h55,        7'd127, 5'd31, 1'b1, {7'd0, 5'd0, 8'h00}),
         cmd_row(KIND_READ,   8'h00,        7'd1,   5'd0,  1'b1, {7'd0, 5'd0, CHAR_BLANK}),
         cmd_row(KIND_WRITE,  CHAR_NEWLINE, 7'd0,   5'd0,  1'b1, {7'd0, 5'd1, 8'h00}),
         cmd_row(KIND_WRITE,  8'h7e,        7'd0,   5'd0,  1'b0, NO_VIEW),
         cmd_row(KIND_READ,   8'h00,        7'd0,   5'd1,  1'b0, NO_VIEW),
         cmd_row(KIND_UNUSED, 8'h00,        7'd0,   5'd0,  1'b0, NO_VIEW)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_cmd(directed_rows[i]);

      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         seg_mode   = $urandom_range(0, 2);
         seg_len    = $urandom_range(40, 200);
         send_eager = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0) begin
            send_cmd(cmd_row(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)),
                             RCOL_W'($urandom_range(0, 127)), RROW_W'($urandom_range(0, 31)),
                             1'b0, NO_VIEW));
            random_count++;
         end
         if (seg_len > RANDOM_ITEMS - random_count) seg_len = RANDOM_ITEMS - random_count;
         repeat (seg_len) begin
            cmd = random_console_cmd(seg_mode);
            send_cmd(cmd);
            random_count++;
         end
      end
      req_ch.valid <= 1'b0;

      while (awaited_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("text_console_writer_top test passed");
      end else begin
         $display("text_console_writer_top test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/tcw_pkg.sv
src/tcw_req_if.sv
src/tcw_rsp_if.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_writer_top.sv
test/testbench.sv
